// ===== src/tlpt_pkg.sv =====
`default_nettype none
package tlpt_pkg;
	localparam int VA_W = 32;
	localparam int DIR_IDX_W = 10;
	localparam int TBL_IDX_W = 10;
	localparam int PAGE_SHIFT = 12;
	localparam int FRAME_W = 20;
	localparam int ENTRY_W = 26;

	localparam logic [2:0] MODE_MAP = 3'd0;
	localparam logic [2:0] MODE_UNMAP = 3'd1;
	localparam logic [2:0] MODE_XLATE = 3'd2;
	localparam logic [2:0] MODE_SETPROT = 3'd3;
	localparam logic [2:0] MODE_GETPROT = 3'd4;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_NOT_MAPPED = 2'd1;
	localparam logic [1:0] ST_NO_SLOT = 2'd2;

	localparam int F_PRESENT = 0;
	localparam int F_WRITABLE = 1;
	localparam int F_USER = 2;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_DIR,
		S_CLEAR,
		S_READ,
		S_EXEC,
		S_OUT
	} tlpt_state_t;

	// controller to datapath
	typedef struct packed {
		logic init_step;
		logic load;
		logic dir_read;
		logic alloc;
		logic clr_start;
		logic clr_step;
		logic entry_read;
		logic exec;
	} tlpt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic init_done;
		logic is_map;
		logic known_mode;
		logic dir_hit;
		logic pool_full;
		logic clr_done;
	} tlpt_sts_t;
endpackage
`default_nettype wire

// ===== src/tlpt_ctrl.sv =====
`default_nettype none
module tlpt_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire                 out_ready,
	output tlpt_pkg::tlpt_cmd_t cmd,
	input  tlpt_pkg::tlpt_sts_t sts
);
	import tlpt_pkg::*;

	tlpt_state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_INIT;
		else state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_INIT: if (sts.init_done) state_nx = S_IDLE;
			S_IDLE: if (in_valid) state_nx = S_DIR;
			S_DIR: begin
				if (!sts.known_mode) state_nx = S_OUT;
				else if (sts.is_map && !sts.dir_hit)
					state_nx = sts.pool_full ? S_OUT : S_CLEAR;
				else state_nx = S_READ;
			end
			S_CLEAR: if (sts.clr_done) state_nx = S_READ;
			S_READ: state_nx = S_EXEC;
			S_EXEC: state_nx = S_OUT;
			S_OUT: if (out_ready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_INIT: cmd.init_step = 1'b1;
			S_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
				cmd.dir_read = in_valid;
			end
			S_DIR: begin
				cmd.alloc = sts.known_mode && sts.is_map && !sts.dir_hit;
				cmd.clr_start = cmd.alloc && !sts.pool_full;
				cmd.entry_read = sts.known_mode && !(sts.is_map && !sts.dir_hit);
			end
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				cmd.entry_read = sts.clr_done;
			end
			S_READ: cmd.exec = 1'b0;
			S_EXEC: cmd.exec = 1'b1;
			S_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/tlpt_dp.sv =====
`default_nettype none
module tlpt_dp #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tlpt_pkg::tlpt_cmd_t cmd,
	output tlpt_pkg::tlpt_sts_t sts,
	input  wire [2:0]           mode,
	input  wire [31:0]          virtual_address,
	input  wire [31:0]          physical_address,
	input  wire                 want_present,
	input  wire                 want_writable,
	input  wire                 want_user,
	input  wire                 want_write_through,
	input  wire                 want_cache_disable,
	input  wire                 want_global,
	output logic [1:0]          status,
	output logic [31:0]         physical_address_out,
	output logic                out_present,
	output logic                out_writable,
	output logic                out_user
);
	import tlpt_pkg::*;

	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam int ADDR_W = SLOT_W + TBL_IDX_W;
	localparam int DEPTH = TABLE_SLOTS * (2 ** TBL_IDX_W);

	// captured request
	logic [2:0]             mode_q;
	logic [VA_W-1:0]        va_q;
	logic [FRAME_W-1:0]     frame_q;
	logic [5:0]             flags_q;

	// directory: valid bit and slot number per entry in one memory
	logic [SLOT_W:0]        dir_mem [2**DIR_IDX_W];
	logic [SLOT_W:0]        dir_rd_q;
	logic [DIR_IDX_W:0]     init_cnt_q;

	logic [CNT_W-1:0]       in_use_q;
	logic [SLOT_W-1:0]      slot_q;

	logic [ENTRY_W-1:0]     tbl_mem [DEPTH];
	logic [ENTRY_W-1:0]     entry_q;
	logic [TBL_IDX_W:0]     clr_cnt_q;

	logic [SLOT_W-1:0]      next_slot;
	logic                   dir_hit;
	logic [DIR_IDX_W-1:0]   d_idx;
	logic [TBL_IDX_W-1:0]   t_idx;
	logic [ADDR_W-1:0]      ent_addr;
	logic                   tbl_we;
	logic [ADDR_W-1:0]      tbl_waddr;
	logic [ENTRY_W-1:0]     tbl_wdata;
	logic                   present;

	assign d_idx = va_q[VA_W-1 -: DIR_IDX_W];
	assign t_idx = va_q[PAGE_SHIFT +: TBL_IDX_W];
	assign ent_addr = {slot_q, t_idx};
	assign present = entry_q[F_PRESENT];
	assign dir_hit = dir_rd_q[SLOT_W];

	// slots are handed out in order and never freed, so the count is the lowest free one
	assign next_slot = in_use_q[SLOT_W-1:0];

	assign sts.init_done = init_cnt_q[DIR_IDX_W];
	assign sts.is_map = (mode_q == MODE_MAP);
	assign sts.known_mode = (mode_q <= MODE_GETPROT);
	assign sts.dir_hit = dir_hit;
	assign sts.pool_full = (in_use_q == CNT_W'(TABLE_SLOTS));
	assign sts.clr_done = clr_cnt_q[TBL_IDX_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			va_q <= virtual_address;
			frame_q <= physical_address[PAGE_SHIFT +: FRAME_W];
			flags_q <= {want_global, want_cache_disable, want_write_through,
				want_user, want_writable, want_present};
		end
	end

	// directory memory: cleared entry by entry after reset, read per request and written on slot allocation
	always_ff @(posedge clk) begin
		if (cmd.dir_read)
			dir_rd_q <= dir_mem[virtual_address[VA_W-1 -: DIR_IDX_W]];
		if (cmd.init_step && !init_cnt_q[DIR_IDX_W])
			dir_mem[init_cnt_q[DIR_IDX_W-1:0]] <= '0;
		else if (cmd.clr_start)
			dir_mem[d_idx] <= {1'b1, next_slot};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			clr_cnt_q <= '0;
			init_cnt_q <= '0;
		end else begin
			if (cmd.init_step && !init_cnt_q[DIR_IDX_W])
				init_cnt_q <= init_cnt_q + 1'b1;
			if (cmd.clr_start) begin
				in_use_q <= in_use_q + 1'b1;
				clr_cnt_q <= '0;
			end else if (cmd.clr_step && !clr_cnt_q[TBL_IDX_W]) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// slot used by this request
	always_ff @(posedge clk) begin
		if (cmd.clr_start) slot_q <= next_slot;
		else if (cmd.load) slot_q <= '0;
		else if (cmd.alloc == 1'b0 && cmd.entry_read && !cmd.clr_step)
			slot_q <= dir_rd_q[SLOT_W-1:0];
	end

	// table write port: clearing sweep or execute write-back
	always_comb begin
		tbl_we = 1'b0;
		tbl_waddr = ent_addr;
		tbl_wdata = '0;
		if (cmd.clr_step && !clr_cnt_q[TBL_IDX_W]) begin
			tbl_we = 1'b1;
			tbl_waddr = {slot_q, clr_cnt_q[TBL_IDX_W-1:0]};
		end else if (cmd.exec) begin
			case (mode_q)
				MODE_MAP: begin
					tbl_we = 1'b1;
					tbl_wdata = {frame_q, flags_q};
				end
				MODE_UNMAP: tbl_we = dir_hit && present;
				MODE_SETPROT: begin
					tbl_we = dir_hit && present;
					tbl_wdata = entry_q;
					tbl_wdata[F_WRITABLE] = flags_q[F_WRITABLE];
					tbl_wdata[F_USER] = flags_q[F_USER];
				end
				default: tbl_we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		entry_q <= tbl_mem[ent_addr];
		if (tbl_we) tbl_mem[tbl_waddr] <= tbl_wdata;
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status <= ST_OK;
			physical_address_out <= '0;
			out_present <= 1'b0;
			out_writable <= 1'b0;
			out_user <= 1'b0;
		end else if (cmd.alloc && sts.pool_full) begin
			status <= ST_NO_SLOT;
		end else if (cmd.exec && mode_q != MODE_MAP) begin
			if (!dir_hit || !present) begin
				status <= ST_NOT_MAPPED;
			end else begin
				case (mode_q)
					MODE_XLATE: physical_address_out <=
						{entry_q[ENTRY_W-1 -: FRAME_W], va_q[PAGE_SHIFT-1:0]};
					MODE_GETPROT: begin
						out_present <= 1'b1;
						out_writable <= entry_q[F_WRITABLE];
						out_user <= entry_q[F_USER];
					end
					default: ;
				endcase
			end
		end
	end
endmodule
`default_nettype wire

// ===== src/two_level_page_table_engine_core.sv =====
// two-level page table engine
// request channel: in_valid/in_ready with mode, virtual_address,
//   physical_address and the want_* flags; one result per request
// result channel: out_valid/out_ready with status, physical_address_out
//   and the out_* protection flags
// a request that hits an allocated directory entry passes the directory read,
//   entry read, execute and result states, then returns to idle, where
//   the next request is taken; one request in flight
// a map that allocates a new table slot first clears the slot's 1024
//   entries through the single table memory write port
// unknown modes and a full pool go from the directory read straight to the result
// after reset the directory memory is cleared one entry a cycle
//   with in_ready low; the in-use slot count is reset in flip-flops at once
// when the receiver stalls the result is held and no new request is taken
`default_nettype none
module two_level_page_table_engine_core #(
	parameter int TABLE_SLOTS = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [2:0]  mode,
	input  wire  [31:0] virtual_address,
	input  wire  [31:0] physical_address,
	input  wire         want_present,
	input  wire         want_writable,
	input  wire         want_user,
	input  wire         want_write_through,
	input  wire         want_cache_disable,
	input  wire         want_global,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [1:0]  status,
	output logic [31:0] physical_address_out,
	output logic        out_present,
	output logic        out_writable,
	output logic        out_user
);
	import tlpt_pkg::*;

	tlpt_cmd_t cmd;
	tlpt_sts_t sts;

	// sequencer
	tlpt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	// directory, slot pool, table memory and result registers
	tlpt_dp #(.TABLE_SLOTS(TABLE_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.mode(mode), .virtual_address(virtual_address),
		.physical_address(physical_address),
		.want_present(want_present), .want_writable(want_writable),
		.want_user(want_user), .want_write_through(want_write_through),
		.want_cache_disable(want_cache_disable), .want_global(want_global),
		.status(status), .physical_address_out(physical_address_out),
		.out_present(out_present), .out_writable(out_writable),
		.out_user(out_user)
	);
endmodule
`default_nettype wire

// ===== src/tlpt_checker.sv =====
`default_nettype none
module tlpt_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [1:0]  status,
	input wire [31:0] physical_address_out,
	input wire        out_present
);
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("request taken while result pending");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3) else $error("bad status");
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != 2'd0) |-> (physical_address_out == 32'd0 && !out_present))
		else $error("error result carries data");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(status)))
		else $error("result dropped");
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_ready) |=> in_valid)
		else $error("request withdrawn before accept");
endmodule
bind two_level_page_table_engine_core tlpt_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.physical_address_out(physical_address_out), .out_present(out_present)
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import tlpt_pkg::*;

	localparam int SLOTS = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [2:0]  mode;
		logic [31:0] va;
		logic [31:0] pa;
		logic [5:0]  flags; // global, cd, wt, user, writable, present
	} pt_req_t;

	typedef struct {
		logic [1:0]  status;
		logic [31:0] pa_out;
		logic        present;
		logic        writable;
		logic        user;
	} pt_rsp_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [2:0] mode;
	logic [31:0] virtual_address;
	logic [31:0] physical_address;
	logic want_present, want_writable, want_user;
	logic want_write_through, want_cache_disable, want_global;
	logic out_valid;
	logic out_ready;
	logic [1:0] status;
	logic [31:0] physical_address_out;
	logic out_present, out_writable, out_user;

	// shadow page table
	logic           dir_used [1024];
	logic [3:0]     dir_slot [1024];
	logic           slot_taken [SLOTS];
	logic [25:0]    pte [SLOTS*1024];
	logic [4:0]     slot_count;

	pt_req_t pending_reqs[$];
	pt_rsp_t expected_rsps[$];
	int errors = 0, accepted = 0, answered = 0, idle_cycles = 0;
	int burst_left, gap_left, stall_cnt;
	int n_full, n_nomap, n_xlate_ok;
	logic [9:0] used_dirs[$];

	two_level_page_table_engine_core #(.TABLE_SLOTS(SLOTS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .virtual_address(virtual_address),
		.physical_address(physical_address),
		.want_present(want_present), .want_writable(want_writable),
		.want_user(want_user), .want_write_through(want_write_through),
		.want_cache_disable(want_cache_disable), .want_global(want_global),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .physical_address_out(physical_address_out),
		.out_present(out_present), .out_writable(out_writable), .out_user(out_user)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// walk the shadow table for one request and produce its response
	function automatic pt_rsp_t walk_page_table(pt_req_t r);
		pt_rsp_t o;
		logic [9:0] d;
		int idx, s;
		logic [25:0] e;
		o = '{ST_OK, 32'd0, 1'b0, 1'b0, 1'b0};
		d = r.va[31:22];
		if (r.mode == MODE_MAP) begin
			if (!dir_used[d]) begin
				s = -1;
				for (int i = 0; i < SLOTS; i++)
					if (!slot_taken[i] && s < 0) s = i;
				if (s < 0) begin
					o.status = ST_NO_SLOT;
					n_full++;
					return o;
				end
				slot_taken[s] = 1'b1;
				for (int i = 0; i < 1024; i++) pte[s*1024 + i] = '0;
				slot_count = slot_count + 5'd1;
				dir_slot[d] = s[3:0];
				dir_used[d] = 1'b1;
				used_dirs.push_back(d);
			end
			pte[dir_slot[d]*1024 + r.va[21:12]] = {r.pa[31:12], r.flags};
		end else if (r.mode <= MODE_GETPROT) begin
			if (!dir_used[d]) begin
				o.status = ST_NOT_MAPPED;
				n_nomap++;
				return o;
			end
			idx = dir_slot[d]*1024 + r.va[21:12];
			e = pte[idx];
			if (!e[F_PRESENT]) begin
				o.status = ST_NOT_MAPPED;
				n_nomap++;
			end else begin
				case (r.mode)
					MODE_UNMAP: pte[idx] = '0;
					MODE_XLATE: begin
						o.pa_out = {e[25:6], r.va[11:0]};
						n_xlate_ok++;
					end
					MODE_SETPROT: begin
						e[F_WRITABLE] = r.flags[1];
						e[F_USER] = r.flags[2];
						pte[idx] = e;
					end
					default: begin
						o.present = 1'b1;
						o.writable = e[F_WRITABLE];
						o.user = e[F_USER];
					end
				endcase
			end
		end
		return o;
	endfunction

	function automatic pt_req_t make_req(logic [2:0] m, logic [31:0] va,
			logic [31:0] pa, logic [5:0] f);
		pt_req_t r;
		r.mode = m;
		r.va = va;
		r.pa = pa;
		r.flags = f;
		return r;
	endfunction

	// random address, mostly in directories already holding a table
	function automatic logic [31:0] pick_va();
		logic [31:0] va;
		va = $urandom;
		if (used_dirs.size() > 0 && $urandom_range(0, 9) < 8)
			va[31:22] = used_dirs[$urandom_range(0, used_dirs.size() - 1)];
		if ($urandom_range(0, 3) != 0)
			va[21:12] = 10'($urandom_range(0, 7)); // small page set for reuse
		return va;
	endfunction

	// stimulus: predictions are made in order, which matches acceptance order
	initial begin
		logic [31:0] va;
		pt_req_t r;
		arst_n = 0;
		for (int i = 0; i < 1024; i++) dir_used[i] = 0;
		for (int i = 0; i < SLOTS; i++) slot_taken[i] = 0;
		slot_count = 0;
		// directed: empty table, every mode, extremes
		pending_reqs.push_back(make_req(MODE_XLATE, 32'h0, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_GETPROT, 32'hFFFF_FFFF, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_MAP, 32'h0000_0ABC, 32'hFFFF_FFFF, 6'h3F));
		pending_reqs.push_back(make_req(MODE_XLATE, 32'h0000_0FFF, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_GETPROT, 32'h0000_0000, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_SETPROT, 32'h0000_0000, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_GETPROT, 32'h0000_0000, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_MAP, 32'hFFFF_FFFF, 32'h0000_0FFF, 6'h3E));
		pending_reqs.push_back(make_req(MODE_XLATE, 32'hFFFF_F123, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_UNMAP, 32'h0000_0000, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_XLATE, 32'h0000_0000, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_UNMAP, 32'h0000_0000, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'h3F));
		pending_reqs.push_back(make_req(3'd7, 32'h0, 32'h0, 6'h0));
		pending_reqs.push_back(make_req(MODE_MAP, 32'h0040_1000, 32'hA5A5_A000, 6'h15));
		pending_reqs.push_back(make_req(MODE_SETPROT, 32'h0040_1000, 32'h0, 6'h06));
		pending_reqs.push_back(make_req(MODE_GETPROT, 32'h0040_1000, 32'h0, 6'h0));
		// fill the pool, then maps that cannot get a slot
		for (int i = 2; i < 17; i++)
			pending_reqs.push_back(make_req(MODE_MAP, {10'(i * 37), 22'h1000},
				$urandom, 6'h01));
		for (int i = 0; i < pending_reqs.size(); i++)
			void'(walk_page_table(pending_reqs[i]));
		pending_reqs.push_back(make_req(MODE_MAP, 32'h3FF0_0000, 32'h1234_5000, 6'h3F));
		void'(walk_page_table(pending_reqs[$]));
		// re-derive expectations from scratch below; reset shadow first
		for (int i = 0; i < 1024; i++) dir_used[i] = 0;
		for (int i = 0; i < SLOTS; i++) slot_taken[i] = 0;
		slot_count = 0;
		used_dirs.delete();
		n_full = 0; n_nomap = 0; n_xlate_ok = 0;
		for (int i = 0; i < pending_reqs.size(); i++)
			expected_rsps.push_back(walk_page_table(pending_reqs[i]));
		// random: the pool is already full, so maps land in existing tables or get no slot
		for (int i = 0; i < 1200; i++) begin
			va = pick_va();
			case ($urandom_range(0, 19))
				0,1,2,3,4,5: r = make_req(MODE_MAP, va, $urandom, 6'($urandom));
				6,7: r = make_req(MODE_UNMAP, va, $urandom, 6'($urandom));
				8,9,10,11: r = make_req(MODE_XLATE, va, $urandom, 6'($urandom));
				12,13: r = make_req(MODE_SETPROT, va, $urandom, 6'($urandom));
				14,15,16,17: r = make_req(MODE_GETPROT, va, $urandom, 6'($urandom));
				default: r = make_req(3'($urandom_range(5, 7)), va, $urandom,
					6'($urandom));
			endcase
			if (r.mode == MODE_MAP && $urandom_range(0, 3) != 0) r.flags[0] = 1'b1;
			pending_reqs.push_back(r);
			expected_rsps.push_back(walk_page_table(r));
		end
		repeat (10) @(posedge clk);
		arst_n = 1;
	end

	// request driver: bursts with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			{mode, virtual_address, physical_address} <= '0;
			{want_present, want_writable, want_user} <= '0;
			{want_write_through, want_cache_disable, want_global} <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) accepted <= accepted + 1;
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				pt_req_t r;
				r = pending_reqs.pop_front();
				in_valid <= 1'b1;
				mode <= r.mode;
				virtual_address <= r.va;
				physical_address <= r.pa;
				{want_global, want_cache_disable, want_write_through,
					want_user, want_writable, want_present} <= r.flags;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 30);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result stall pattern: periodic ready windows mixed with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt[8:7] == 2'd3) out_ready <= 1'b1;
			else out_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	// response monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				pt_rsp_t x;
				answered <= answered + 1;
				if (expected_rsps.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected response status=%0d", status);
				end else begin
					x = expected_rsps.pop_front();
					if (status !== x.status || physical_address_out !== x.pa_out
						|| out_present !== x.present || out_writable !== x.writable
						|| out_user !== x.user) begin
						errors++;
						if (errors <= 10)
							$display("response %0d: exp st=%0d pa=%h p/w/u=%b%b%b got st=%0d pa=%h p/w/u=%b%b%b",
								answered, x.status, x.pa_out, x.present, x.writable, x.user,
								status, physical_address_out, out_present, out_writable,
								out_user);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	// end of run and watchdog
	initial begin
		@(posedge arst_n);
		while ((pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
			&& idle_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d responses outstanding", expected_rsps.size());
			$display("Mismatches found");
		end else begin
			repeat (20) @(posedge clk);
			$display("sent %0d requests, checked %0d responses", accepted, answered);
			$display("%0d translations, %0d unmapped, %0d pool full",
				n_xlate_ok, n_nomap, n_full);
			if (errors == 0 && expected_rsps.size() == 0)
				$display("No mismatches found");
			else
				$display("Mismatches found");
		end
		$finish;
	end
endmodule
